/* src/pfc_ss_pkg.sv */
package pfc_ss_pkg;

   localparam int TIMER_WIDTH_DEF = 16;
   localparam int CFG_WIDTH       = 16;
   localparam int CSR_IDX_WIDTH   = 2;
   localparam int CMD_WIDTH       = 2;
   localparam int PHASE_WIDTH     = 3;
   localparam int STATUS_WIDTH    = 2;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_INIT_DELAY   = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SOFT_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RELAY_TIMEOUT = 2'd2;

   localparam logic [CFG_WIDTH-1:0] INIT_DELAY_RST    = 16'd200;
   localparam logic [CFG_WIDTH-1:0] SOFT_TIMEOUT_RST  = 16'd5000;
   localparam logic [CFG_WIDTH-1:0] RELAY_TIMEOUT_RST = 16'd3000;

   localparam logic [CMD_WIDTH-1:0] CMD_NONE  = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_START = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_STOP  = 2'd2;

   localparam logic [PHASE_WIDTH-1:0] PHASE_INIT  = 3'd0;
   localparam logic [PHASE_WIDTH-1:0] PHASE_IDLE  = 3'd1;
   localparam logic [PHASE_WIDTH-1:0] PHASE_SOFT  = 3'd2;
   localparam logic [PHASE_WIDTH-1:0] PHASE_RELAY = 3'd3;
   localparam logic [PHASE_WIDTH-1:0] PHASE_RUN   = 3'd4;

   localparam logic [STATUS_WIDTH-1:0] STATUS_INIT    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_IDLE    = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_RUNNING = 2'd2;

   typedef enum logic [4:0] {
      ST_INIT  = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SOFT  = 5'b00100,
      ST_RELAY = 5'b01000,
      ST_RUN   = 5'b10000
   } state_type;

   typedef struct packed {
      logic [CMD_WIDTH-1:0] cmd;
      logic                 cfg_ready;
      logic                 hw_ready;
      logic                 protect_latched;
      logic                 vbus_ready;
      logic                 relay_closed;
   } req_item_type;

   typedef struct packed {
      logic [PHASE_WIDTH-1:0]  phase;
      logic [STATUS_WIDTH-1:0] run_status;
      logic                    relay_on_pulse;
      logic                    relay_off_pulse;
      logic                    control_on_pulse;
      logic                    control_off_pulse;
      logic                    binding_locked;
   } rsp_item_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] init_delay_ticks;
      logic [CFG_WIDTH-1:0] soft_start_timeout_ticks;
      logic [CFG_WIDTH-1:0] relay_timeout_ticks;
   } cfg_type;

endpackage

/* src/pfc_ss_if.sv */
interface pfc_ss_req_if import pfc_ss_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CMD_WIDTH-1:0] cmd;
   logic                 cfg_ready;
   logic                 hw_ready;
   logic                 protect_latched;
   logic                 vbus_ready;
   logic                 relay_closed;

   modport source (output valid, cmd, cfg_ready, hw_ready, protect_latched, vbus_ready,
                   relay_closed, input ready);
   modport sink (input valid, cmd, cfg_ready, hw_ready, protect_latched, vbus_ready,
                 relay_closed, output ready);
endinterface

interface pfc_ss_rsp_if import pfc_ss_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [PHASE_WIDTH-1:0]  phase;
   logic [STATUS_WIDTH-1:0] run_status;
   logic                    relay_on_pulse;
   logic                    relay_off_pulse;
   logic                    control_on_pulse;
   logic                    control_off_pulse;
   logic                    binding_locked;

   modport source (output valid, phase, run_status, relay_on_pulse, relay_off_pulse,
                   control_on_pulse, control_off_pulse, binding_locked, input ready);
   modport sink (input valid, phase, run_status, relay_on_pulse, relay_off_pulse,
                 control_on_pulse, control_off_pulse, binding_locked, output ready);
endinterface

interface pfc_ss_csr_if import pfc_ss_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_WIDTH-1:0] index;
   logic [CFG_WIDTH-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* src/pfc_ss_csr.sv */
module pfc_ss_csr
   import pfc_ss_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   pfc_ss_csr_if.sink   csr_ch,
   output cfg_type      cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_INIT_DELAY:    cfg_in.init_delay_ticks = csr_ch.data;
            CSR_SOFT_TIMEOUT:  cfg_in.soft_start_timeout_ticks = csr_ch.data;
            CSR_RELAY_TIMEOUT: cfg_in.relay_timeout_ticks = csr_ch.data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.init_delay_ticks         <= INIT_DELAY_RST;
         cfg_ff.soft_start_timeout_ticks <= SOFT_TIMEOUT_RST;
         cfg_ff.relay_timeout_ticks      <= RELAY_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* src/pfc_ss_ctrl.sv */
module pfc_ss_ctrl
   import pfc_ss_pkg::*;
#(
   parameter int TimerWidth = TIMER_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   localparam int LimWidth = (TimerWidth > CFG_WIDTH) ? TimerWidth : CFG_WIDTH;
   localparam logic [LimWidth-1:0] TimerMax = LimWidth'({TimerWidth{1'b1}});

   function automatic logic [TimerWidth-1:0] clamp_limit(input logic [CFG_WIDTH-1:0] r);
      logic [LimWidth-1:0] ext;
      ext = LimWidth'(r);
      if (ext > TimerMax) begin
         ext = TimerMax;
      end
      return ext[TimerWidth-1:0];
   endfunction

   state_type               state_ff, state_in;
   logic [CMD_WIDTH-1:0]    pend_ff, pend_in;
   logic [TimerWidth-1:0]   timer_ff, timer_in;
   logic                    lock_ff, lock_in;

   state_type               eff_state;
   state_type               next_state;
   logic [CMD_WIDTH-1:0]    pend_cur;
   logic [TimerWidth-1:0]   lim_cur;
   logic [TimerWidth-1:0]   timer_step;
   logic                    timer_below;
   logic                    rly_on, rly_off, ctl_on, ctl_off;

   always_comb begin
      pend_cur = (item.cmd == CMD_START || item.cmd == CMD_STOP) ? item.cmd : pend_ff;
      unique case (state_ff)
         ST_SOFT:  lim_cur = clamp_limit(cfg.soft_start_timeout_ticks);
         ST_RELAY: lim_cur = clamp_limit(cfg.relay_timeout_ticks);
         default:  lim_cur = clamp_limit(cfg.init_delay_ticks);
      endcase
      timer_below = timer_ff < lim_cur;
      timer_step  = timer_below ? timer_ff + 1'b1 : timer_ff;

      eff_state  = state_ff;
      next_state = state_ff;
      timer_in   = timer_ff;
      pend_in    = pend_cur;
      lock_in    = lock_ff;
      rly_on     = 1'b0;
      rly_off    = 1'b0;
      ctl_on     = 1'b0;
      ctl_off    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            pend_in = CMD_NONE;
            if (pend_cur == CMD_START && item.hw_ready && !item.protect_latched) begin
               next_state = ST_SOFT;
            end
         end
         ST_SOFT: begin
            timer_in = timer_step;
            pend_in  = CMD_NONE;
            if (pend_cur == CMD_STOP) begin
               next_state = ST_IDLE;
            end else if (item.vbus_ready) begin
               next_state = ST_RELAY;
            end else if (timer_step >= lim_cur) begin
               next_state = ST_IDLE;
            end
         end
         ST_RELAY: begin
            timer_in = timer_step;
            pend_in  = CMD_NONE;
            if (pend_cur == CMD_STOP) begin
               next_state = ST_IDLE;
            end else if (item.relay_closed) begin
               next_state = ST_RUN;
            end else if (timer_step >= lim_cur) begin
               next_state = ST_IDLE;
            end
         end
         ST_RUN: begin
            pend_in = CMD_NONE;
            if (pend_cur == CMD_STOP) begin
               next_state = ST_IDLE;
            end
         end
         default: begin
            eff_state  = ST_INIT;
            next_state = ST_INIT;
            if (timer_below) begin
               timer_in = timer_step;
            end else if (item.cfg_ready) begin
               next_state = ST_IDLE;
            end
         end
      endcase

      if (next_state != eff_state) begin
         if (eff_state == ST_IDLE) begin
            lock_in = 1'b1;
         end else if (eff_state == ST_RUN) begin
            ctl_off = 1'b1;
            rly_off = 1'b1;
         end
         unique case (next_state)
            ST_IDLE: begin
               lock_in = 1'b0;
               rly_off = 1'b1;
            end
            ST_SOFT: timer_in = '0;
            ST_RELAY: begin
               timer_in = '0;
               rly_on   = 1'b1;
            end
            ST_RUN: begin
               ctl_on = 1'b1;
               rly_on = 1'b1;
            end
            default: timer_in = '0;
         endcase
      end
      state_in = next_state;

      unique case (next_state)
         ST_IDLE: begin
            result.phase      = PHASE_IDLE;
            result.run_status = STATUS_IDLE;
         end
         ST_SOFT: begin
            result.phase      = PHASE_SOFT;
            result.run_status = STATUS_RUNNING;
         end
         ST_RELAY: begin
            result.phase      = PHASE_RELAY;
            result.run_status = STATUS_RUNNING;
         end
         ST_RUN: begin
            result.phase      = PHASE_RUN;
            result.run_status = STATUS_RUNNING;
         end
         default: begin
            result.phase      = PHASE_INIT;
            result.run_status = STATUS_INIT;
         end
      endcase
      result.relay_on_pulse    = rly_on;
      result.relay_off_pulse   = rly_off;
      result.control_on_pulse  = ctl_on;
      result.control_off_pulse = ctl_off;
      result.binding_locked    = lock_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         pend_ff  <= CMD_NONE;
         timer_ff <= '0;
         lock_ff  <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         timer_ff <= timer_in;
         lock_ff  <= lock_in;
      end
   end

`ifndef SYNTHESIS
   a_lock_on_leave_idle: assert property (@(posedge clock) disable iff (reset)
      advance && state_ff == ST_IDLE && state_in != ST_IDLE |=> lock_ff)
      else $error("binding not locked after leaving idle");

   a_ctl_on_with_relay: assert property (@(posedge clock) disable iff (reset)
      advance && result.control_on_pulse |-> result.relay_on_pulse &&
      !result.relay_off_pulse)
      else $error("control on without relay on");

   a_cmd_consumed: assert property (@(posedge clock) disable iff (reset)
      advance && state_ff != ST_INIT |=> pend_ff == CMD_NONE)
      else $error("pending command not consumed");

   a_unlocked_in_idle: assert property (@(posedge clock) disable iff (reset)
      advance && state_in == ST_IDLE && state_ff != ST_IDLE |=> !lock_ff)
      else $error("binding locked on entering idle");
`endif

endmodule

/* src/pfc_startup_sequencer_unit.sv */
// An accepted item is held in the input register; its result is registered
// on advance. Throughput: one item per cycle unless the response stalls;
// the state update is combinational logic from input to result register.
// Reset: synchronous, active high; state goes to init, no pending command,
// timer zero, binding unlocked, configuration registers to their defaults.
module pfc_startup_sequencer_unit
   import pfc_ss_pkg::*;
#(
   parameter int TimerWidth = TIMER_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   pfc_ss_req_if.sink   req_ch,
   pfc_ss_rsp_if.source rsp_ch,
   pfc_ss_csr_if.sink   csr_ch
);

   cfg_type      cfg;
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   rsp_item_type result;
   logic         advance;
   logic         req_fire;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   pfc_ss_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   pfc_ss_ctrl #(
      .TimerWidth (TimerWidth)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.cmd             <= req_ch.cmd;
         in_item_ff.cfg_ready       <= req_ch.cfg_ready;
         in_item_ff.hw_ready        <= req_ch.hw_ready;
         in_item_ff.protect_latched <= req_ch.protect_latched;
         in_item_ff.vbus_ready      <= req_ch.vbus_ready;
         in_item_ff.relay_closed    <= req_ch.relay_closed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.phase             = rsp_item_ff.phase;
   assign rsp_ch.run_status        = rsp_item_ff.run_status;
   assign rsp_ch.relay_on_pulse    = rsp_item_ff.relay_on_pulse;
   assign rsp_ch.relay_off_pulse   = rsp_item_ff.relay_off_pulse;
   assign rsp_ch.control_on_pulse  = rsp_item_ff.control_on_pulse;
   assign rsp_ch.control_off_pulse = rsp_item_ff.control_off_pulse;
   assign rsp_ch.binding_locked    = rsp_item_ff.binding_locked;

`ifndef SYNTHESIS
   a_no_item_lost: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("held item dropped");

   a_result_follows_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result missing after advance");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |-> !advance)
      else $error("pending result overwritten");
`endif

endmodule
